### hw/rtl/largest_empty_square_finder_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the largest empty square finder
// Property wrappers clocked on clock and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef LARGEST_EMPTY_SQUARE_FINDER_UNIT_MACROS_SVH
`define LARGEST_EMPTY_SQUARE_FINDER_UNIT_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define LESF_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define LESF_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`else

`define LESF_ASSERT_NOW(label, ante, cons, msg)
`define LESF_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

### hw/rtl/lesf_pkg.sv
// ----------------------------------------------------------------------------
// lesf_pkg
// Shared constants for the largest empty square finder.
// ----------------------------------------------------------------------------
package lesf_pkg;

   localparam int MAX_COLS = 1024;
   localparam int MAX_ROWS = 1024;

   localparam int COL_W   = $clog2(MAX_COLS);
   localparam int ROW_W   = $clog2(MAX_ROWS);
   localparam int LEN_W   = 11;
   localparam int SCORE_W = 11;
   localparam int BYTE_W  = 8;
   localparam int CSR_IDX_W = 2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_LENGTH    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OBSTACLE_BYTE = 2'd1;

   localparam logic [LEN_W-1:0]  ROW_LENGTH_RESET    = 11'd1024;
   localparam logic [BYTE_W-1:0] OBSTACLE_BYTE_RESET = 8'd111;

endpackage

### hw/rtl/largest_empty_square_finder_unit.sv
// ----------------------------------------------------------------------------
// largest_empty_square_finder_unit
// Takes one map cell per cycle while req_ready is high and reports the
// largest obstacle-free square; each cell takes a single line buffer read.
// A last cell passes the score stage register, then loads the result word.
// req_ready drops only while a result waits and another last cell needs the
// output register. Synchronous reset clears counters, neighbors and best
// square; the line buffer is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
`include "largest_empty_square_finder_unit_macros.svh"

module largest_empty_square_finder_unit (
   input  logic                              clock,
   input  logic                              reset,
   // configuration
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [lesf_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [lesf_pkg::LEN_W-1:0]        csr_wdata,
   // cells
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [lesf_pkg::BYTE_W-1:0]       req_cell_byte,
   input  logic                              req_last_cell,
   // result
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [lesf_pkg::SCORE_W-1:0]      rsp_square_size,
   output logic [9:0]                        rsp_top_row,
   output logic [9:0]                        rsp_left_col,
   output logic                              rsp_row_overflow
);

   typedef struct packed {
      logic                         last;
      logic                         row_end;
      logic                         obst;
      logic [lesf_pkg::COL_W-1:0]   col;
      logic [lesf_pkg::ROW_W-1:0]   row;
      logic                         ovf;
   } s1_type;

   localparam logic [lesf_pkg::LEN_W-1:0] LEN_MAX =
      lesf_pkg::LEN_W'(lesf_pkg::MAX_COLS);
   localparam logic [lesf_pkg::ROW_W:0] ROW_LIMIT =
      (lesf_pkg::ROW_W+1)'(lesf_pkg::MAX_ROWS);

   // configuration registers
   logic [lesf_pkg::LEN_W-1:0]  row_length_ff, row_length_in;
   logic [lesf_pkg::BYTE_W-1:0] obstacle_ff, obstacle_in;

   // issue-side counters
   logic [lesf_pkg::COL_W-1:0] col_ff, col_in;
   logic [lesf_pkg::ROW_W-1:0] row_ff, row_in;
   logic                       ovf_ff, ovf_in;

   // score stage
   logic   s1_valid_ff, s1_valid_in;
   s1_type s1_ff, s1_in;
   logic [lesf_pkg::SCORE_W-1:0] left_ff, left_in;
   logic [lesf_pkg::SCORE_W-1:0] diag_ff, diag_in;
   logic [lesf_pkg::SCORE_W-1:0] best_size_ff, best_size_in;
   logic [lesf_pkg::ROW_W-1:0]   best_row_ff, best_row_in;
   logic [lesf_pkg::COL_W-1:0]   best_col_ff, best_col_in;

   // result register
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [lesf_pkg::SCORE_W-1:0] res_size_ff, res_size_in;
   logic [lesf_pkg::ROW_W-1:0]   res_row_ff, res_row_in;
   logic [lesf_pkg::COL_W-1:0]   res_col_ff, res_col_in;
   logic                         res_ovf_ff, res_ovf_in;

   logic                         accept;
   logic                         advance;
   logic                         fire;
   logic [lesf_pkg::LEN_W-1:0]   len_eff;
   logic                         row_end;
   logic [lesf_pkg::SCORE_W-1:0] up;
   logic [lesf_pkg::SCORE_W-1:0] min_ul;
   logic [lesf_pkg::SCORE_W-1:0] min3;
   logic [lesf_pkg::SCORE_W-1:0] score;
   logic                         better;
   logic [lesf_pkg::SCORE_W-1:0] top_diff;
   logic [lesf_pkg::SCORE_W-1:0] left_diff;

   // ---------------------------------------------------------------- config
   assign csr_ready = 1'b1;

   always_comb begin
      row_length_in = row_length_ff;
      obstacle_in   = obstacle_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            lesf_pkg::CSR_ROW_LENGTH:    row_length_in = csr_wdata;
            lesf_pkg::CSR_OBSTACLE_BYTE: obstacle_in   = csr_wdata[lesf_pkg::BYTE_W-1:0];
            default:                     ;
         endcase
      end
   end

   always_comb begin
      if (row_length_ff == '0) begin
         len_eff = lesf_pkg::LEN_W'(1);
      end else if (row_length_ff > LEN_MAX) begin
         len_eff = LEN_MAX;
      end else begin
         len_eff = row_length_ff;
      end
   end

   // ------------------------------------------------------------ handshake
   // hold the score stage only when a last cell cannot leave it
   assign advance   = !(s1_valid_ff && s1_ff.last && rsp_valid_ff && !rsp_ready);
   assign req_ready = advance;
   assign accept    = req_valid && req_ready;
   assign fire      = s1_valid_ff && advance;

   // ------------------------------------------------------------ issue side
   assign row_end = (lesf_pkg::LEN_W'({1'b0, col_ff}) + lesf_pkg::LEN_W'(1)) >= len_eff;

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      ovf_in = ovf_ff;
      if (accept) begin
         if (req_last_cell) begin
            col_in = '0;
            row_in = '0;
            ovf_in = 1'b0;
         end else if (row_end) begin
            col_in = '0;
            if (({1'b0, row_ff} + (lesf_pkg::ROW_W+1)'(1)) >= ROW_LIMIT) begin
               ovf_in = 1'b1;
            end else begin
               row_in = row_ff + lesf_pkg::ROW_W'(1);
            end
         end else begin
            col_in = col_ff + lesf_pkg::COL_W'(1);
         end
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_in       = s1_ff;
      if (advance) begin
         s1_valid_in   = accept;
         s1_in.last    = req_last_cell;
         s1_in.row_end = row_end;
         s1_in.obst    = (req_cell_byte == obstacle_ff);
         s1_in.col     = col_ff;
         s1_in.row     = row_ff;
         s1_in.ovf     = ovf_ff;
      end
   end

   // line buffer: read at issue, write back from the score stage
   lesf_ram #(
      .WIDTH (lesf_pkg::SCORE_W),
      .DEPTH (lesf_pkg::MAX_COLS)
   ) u_line_buf (
      .clock   (clock),
      .wr_en   (fire),
      .wr_addr (s1_ff.col),
      .wr_data (score),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .rd_data (up)
   );

   // ----------------------------------------------------------- score stage
   assign min_ul = (up < left_ff) ? up : left_ff;
   assign min3   = (diag_ff < min_ul) ? diag_ff : min_ul;

   always_comb begin
      if (s1_ff.obst) begin
         score = '0;
      end else if (s1_ff.row == '0 || s1_ff.col == '0) begin
         score = lesf_pkg::SCORE_W'(1);
      end else begin
         score = min3 + lesf_pkg::SCORE_W'(1);
      end
   end

   assign better = score > best_size_ff;

   always_comb begin
      left_in      = left_ff;
      diag_in      = diag_ff;
      best_size_in = best_size_ff;
      best_row_in  = best_row_ff;
      best_col_in  = best_col_ff;
      res_size_in  = res_size_ff;
      res_row_in   = res_row_ff;
      res_col_in   = res_col_ff;
      res_ovf_in   = res_ovf_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (fire) begin
         if (s1_ff.last) begin
            // report the final best, then start a fresh map
            res_size_in  = better ? score : best_size_ff;
            res_row_in   = better ? s1_ff.row : best_row_ff;
            res_col_in   = better ? s1_ff.col : best_col_ff;
            res_ovf_in   = s1_ff.ovf;
            rsp_valid_in = 1'b1;
            left_in      = '0;
            diag_in      = '0;
            best_size_in = '0;
            best_row_in  = '0;
            best_col_in  = '0;
         end else begin
            if (better) begin
               best_size_in = score;
               best_row_in  = s1_ff.row;
               best_col_in  = s1_ff.col;
            end
            if (s1_ff.row_end) begin
               left_in = '0;
               diag_in = '0;
            end else begin
               left_in = score;
               diag_in = up;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_length_ff <= lesf_pkg::ROW_LENGTH_RESET;
         obstacle_ff   <= lesf_pkg::OBSTACLE_BYTE_RESET;
         col_ff        <= '0;
         row_ff        <= '0;
         ovf_ff        <= 1'b0;
         s1_valid_ff   <= 1'b0;
         left_ff       <= '0;
         diag_ff       <= '0;
         best_size_ff  <= '0;
         best_row_ff   <= '0;
         best_col_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         row_length_ff <= row_length_in;
         obstacle_ff   <= obstacle_in;
         col_ff        <= col_in;
         row_ff        <= row_in;
         ovf_ff        <= ovf_in;
         s1_valid_ff   <= s1_valid_in;
         left_ff       <= left_in;
         diag_ff       <= diag_in;
         best_size_ff  <= best_size_in;
         best_row_ff   <= best_row_in;
         best_col_ff   <= best_col_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      s1_ff      <= s1_in;
      res_size_ff <= res_size_in;
      res_row_ff  <= res_row_in;
      res_col_ff  <= res_col_in;
      res_ovf_ff  <= res_ovf_in;
   end

   // ---------------------------------------------------------------- output
   // corner = bottom-right + 1 - size, clipped to zero
   assign top_diff  = lesf_pkg::SCORE_W'({1'b0, res_row_ff}) + lesf_pkg::SCORE_W'(1)
                      - res_size_ff;
   assign left_diff = lesf_pkg::SCORE_W'({1'b0, res_col_ff}) + lesf_pkg::SCORE_W'(1)
                      - res_size_ff;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_square_size  = res_size_ff;
   assign rsp_row_overflow = res_ovf_ff;
   assign rsp_top_row  = (res_size_ff != '0 &&
                          (lesf_pkg::SCORE_W'({1'b0, res_row_ff}) + lesf_pkg::SCORE_W'(1))
                          >= res_size_ff) ? top_diff[9:0] : 10'd0;
   assign rsp_left_col = (res_size_ff != '0 &&
                          (lesf_pkg::SCORE_W'({1'b0, res_col_ff}) + lesf_pkg::SCORE_W'(1))
                          >= res_size_ff) ? left_diff[9:0] : 10'd0;

   // ------------------------------------------------------------ assertions
   `LESF_ASSERT_NEXT(a_last_clears_counters, accept && req_last_cell, col_ff == '0 && row_ff == '0 && !ovf_ff, "counters not cleared after last cell")
   `LESF_ASSERT_NEXT(a_last_gives_result, fire && s1_ff.last, rsp_valid_ff && best_size_ff == '0, "last cell did not load a result")
   `LESF_ASSERT_NOW(a_size_bounded, rsp_valid_ff, res_size_ff <= LEN_MAX, "square size exceeds row capacity")
   `LESF_ASSERT_NOW(a_ovf_at_limit, $rose(ovf_ff), $past(row_ff) == lesf_pkg::ROW_W'(lesf_pkg::MAX_ROWS - 1), "row overflow set below the row limit")

endmodule

### hw/rtl/lesf_ram.sv
// ----------------------------------------------------------------------------
// lesf_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module lesf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      // read data holds until the next read
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
